[rtl/core/mm_pkg.sv]
`default_nettype none

package mm_pkg;

	// Largest matrix dimension and the derived store geometry.
	localparam int MAX_DIM     = 8;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// Fixed field widths.
	localparam int IDX_W     = 3;
	localparam int DIM_W     = 4;
	localparam int VAL_W     = 16;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int ACC_W     = PROD_W + $clog2(MAX_DIM);
	localparam int FRAC_BITS = 8;
	localparam int Q_W       = ACC_W - FRAC_BITS;

	// Command queue depth between the front and the back.
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [DIM_W-1:0]  dim_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Input function codes.
	typedef enum logic [1:0] {
		FUNC_LOAD_A  = 2'd0,
		FUNC_LOAD_B  = 2'd1,
		FUNC_COMPUTE = 2'd2
	} func_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_A_ROWS    = 2'd0,
		REG_INNER_DIM = 2'd1,
		REG_B_COLS    = 2'd2
	} reg_index_t;

	// A classified command handed from the front to the back.
	typedef struct packed {
		func_t                    kind;
		addr_t                    addr;
		logic signed [VAL_W-1:0]  value;
	} cmd_t;

	// Matrix dimensions as held in the configuration registers.
	typedef struct packed {
		dim_t a_rows;
		dim_t inner_dim;
		dim_t b_cols;
	} dims_t;

	// Zero reads as one, anything above the maximum reads as the maximum.
	function automatic dim_t clamp_dim(input dim_t d);
		dim_t r;
		if (d == '0) begin
			r = DIM_W'(1);
		end else if (d > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = d;
		end
		return r;
	endfunction

	// Row-major location of an element in a store.
	function automatic addr_t mem_addr(input idx_t r, input idx_t c);
		return ADDR_W'(int'(r) * MAX_DIM + int'(c));
	endfunction

endpackage

`default_nettype wire

[rtl/core/mm_front.sv]
`default_nettype none

module mm_front (
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    func,
	input  wire mm_pkg::idx_t                  row,
	input  wire mm_pkg::idx_t                  col,
	input  wire logic signed [mm_pkg::VAL_W-1:0] value,
	input  wire logic                          cmd_full,
	output logic                               cmd_push,
	output mm_pkg::cmd_t                       cmd_data
);
	import mm_pkg::*;

	logic keep;
	logic in_range;

	// Loads outside the store and unused codes are dropped at the door.
	assign in_range = (DIM_W'(row) < DIM_W'(MAX_DIM)) && (DIM_W'(col) < DIM_W'(MAX_DIM));

	always_comb begin
		unique case (func)
			FUNC_LOAD_A, FUNC_LOAD_B: keep = in_range;
			FUNC_COMPUTE:             keep = 1'b1;
			default:                  keep = 1'b0;
		endcase
	end

	// A transaction is taken whenever the queue has room.
	assign in_ready = !cmd_full;
	assign cmd_push = in_valid && in_ready && keep;

	assign cmd_data.kind  = func_t'(func);
	assign cmd_data.addr  = mem_addr(row, col);
	assign cmd_data.value = value;

endmodule

`default_nettype wire

[rtl/core/mm_cmd_fifo.sv]
`default_nettype none

module mm_cmd_fifo (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire mm_pkg::cmd_t push_data,
	input  wire logic         pop,
	output mm_pkg::cmd_t      pop_data,
	output logic              full,
	output logic              empty
);
	import mm_pkg::*;

	cmd_t                 entry_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full     = (count_q == CMD_CNT_W'(CMD_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CMD_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CMD_CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[rtl/core/mm_back.sv]
`default_nettype none

module mm_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mm_pkg::dims_t         dims,
	input  wire logic                  cmd_empty,
	input  wire mm_pkg::cmd_t          cmd_data,
	output logic                       cmd_pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output mm_pkg::idx_t               out_row,
	output mm_pkg::idx_t               out_col,
	output logic signed [mm_pkg::VAL_W-1:0] product,
	output logic                       saturated,
	output logic                       last
);
	import mm_pkg::*;

	// Element stores.
	logic signed [VAL_W-1:0] a_mem [STORE_DEPTH];
	logic signed [VAL_W-1:0] b_mem [STORE_DEPTH];

	// Sequencer.
	logic busy_q;
	idx_t r_q, c_q, k_q;
	logic last_k, last_c, last_r;
	logic pipe_en;

	// Pipeline stages.
	logic                     valid_s1, first_s1, lastk_s1, lastel_s1;
	idx_t                     r_s1, c_s1;
	logic signed [VAL_W-1:0]  a_rd_s1, b_rd_s1;
	logic                     valid_s2, first_s2, lastk_s2, lastel_s2;
	idx_t                     r_s2, c_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     done_s3, lastel_s3;
	idx_t                     r_s3, c_s3;
	logic signed [ACC_W-1:0]  acc_s3;

	// Output register.
	logic                     out_valid_q;
	idx_t                     out_row_q, out_col_q;
	logic signed [VAL_W-1:0]  product_q;
	logic                     saturated_q, last_q;

	logic signed [Q_W-1:0]    q_full;
	logic                     clip;
	logic signed [VAL_W-1:0]  q_sat;

	// The whole compute pipeline moves only when the output register can take a value.
	assign pipe_en = !out_valid_q || out_ready;

	// A new command is taken once the walk over the previous compute has been issued.
	assign cmd_pop = !cmd_empty && !busy_q;

	assign last_k = (DIM_W'(k_q) + DIM_W'(1)) == dims.inner_dim;
	assign last_c = (DIM_W'(c_q) + DIM_W'(1)) == dims.b_cols;
	assign last_r = (DIM_W'(r_q) + DIM_W'(1)) == dims.a_rows;

	// Walk over rows, columns and the inner dimension, one product per cycle while the pipeline moves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			r_q    <= '0;
			c_q    <= '0;
			k_q    <= '0;
		end else if (cmd_pop && cmd_data.kind == FUNC_COMPUTE) begin
			busy_q <= 1'b1;
			r_q    <= '0;
			c_q    <= '0;
			k_q    <= '0;
		end else if (busy_q && pipe_en) begin
			if (!last_k) begin
				k_q <= k_q + IDX_W'(1);
			end else begin
				k_q <= '0;
				if (!last_c) begin
					c_q <= c_q + IDX_W'(1);
				end else begin
					c_q <= '0;
					if (!last_r) begin
						r_q <= r_q + IDX_W'(1);
					end else begin
						busy_q <= 1'b0;
					end
				end
			end
		end
	end

	// Store writes from load commands and registered reads for the walk.
	always_ff @(posedge clk) begin
		if (cmd_pop && cmd_data.kind == FUNC_LOAD_A) begin
			a_mem[cmd_data.addr] <= cmd_data.value;
		end
		if (cmd_pop && cmd_data.kind == FUNC_LOAD_B) begin
			b_mem[cmd_data.addr] <= cmd_data.value;
		end
		if (pipe_en) begin
			a_rd_s1 <= a_mem[mem_addr(r_q, k_q)];
			b_rd_s1 <= b_mem[mem_addr(k_q, c_q)];
		end
	end

	// Pipeline control bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_s3  <= 1'b0;
		end else if (pipe_en) begin
			valid_s1 <= busy_q;
			valid_s2 <= valid_s1;
			done_s3  <= valid_s2 && lastk_s2;
		end
	end

	// Pipeline payload: tags, product and accumulator.
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			first_s1  <= (k_q == '0);
			lastk_s1  <= last_k;
			lastel_s1 <= last_r && last_c;
			r_s1      <= r_q;
			c_s1      <= c_q;

			first_s2  <= first_s1;
			lastk_s2  <= lastk_s1;
			lastel_s2 <= lastel_s1;
			r_s2      <= r_s1;
			c_s2      <= c_s1;
			prod_s2   <= PROD_W'(a_rd_s1) * PROD_W'(b_rd_s1);

			if (valid_s2) begin
				acc_s3 <= first_s2 ? ACC_W'(prod_s2) : acc_s3 + ACC_W'(prod_s2);
			end
			lastel_s3 <= lastel_s2;
			r_s3      <= r_s2;
			c_s3      <= c_s2;
		end
	end

	// Floor shift out the fraction, then clip to the 16-bit range.
	always_comb begin
		q_full = Q_W'(acc_s3 >>> FRAC_BITS);
		clip   = !((&q_full[Q_W-1:VAL_W-1]) || !(|q_full[Q_W-1:VAL_W-1]));
		if (!clip) begin
			q_sat = q_full[VAL_W-1:0];
		end else if (q_full[Q_W-1]) begin
			q_sat = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			q_sat = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	// Output register: holds a result until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pipe_en) begin
			out_valid_q <= done_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en && done_s3) begin
			out_row_q   <= r_s3;
			out_col_q   <= c_s3;
			product_q   <= q_sat;
			saturated_q <= clip;
			last_q      <= lastel_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign product   = product_q;
	assign saturated = saturated_q;
	assign last      = last_q;

endmodule

`default_nettype wire

[rtl/core/matrix_multiply_top.sv]
// Loads go into the stores one per cycle while the queue has room and no compute
// is busy. A compute walks a_rows * b_cols * inner_dim multiply-accumulate steps,
// one per cycle through the single multiplier while the output can take a result,
// via the store read, product, accumulator and output registers.
// Reset clears the dimension registers to 8 and empties the queue and pipeline;
// the element stores are not cleared and hold nothing defined until loaded.
`default_nettype none

module matrix_multiply_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire mm_pkg::dim_t                  cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    func,
	input  wire mm_pkg::idx_t                  row,
	input  wire mm_pkg::idx_t                  col,
	input  wire logic signed [mm_pkg::VAL_W-1:0] value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output mm_pkg::idx_t                       out_row,
	output mm_pkg::idx_t                       out_col,
	output logic signed [mm_pkg::VAL_W-1:0]    product,
	output logic                               saturated,
	output logic                               last
);
	import mm_pkg::*;

	dims_t dims_q;
	cmd_t  push_data;
	cmd_t  pop_data;
	logic  cmd_push, cmd_pop, cmd_full, cmd_empty;

	// Dimension registers, clamped on write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q.a_rows    <= clamp_dim(DIM_W'(8));
			dims_q.inner_dim <= clamp_dim(DIM_W'(8));
			dims_q.b_cols    <= clamp_dim(DIM_W'(8));
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_A_ROWS:    dims_q.a_rows    <= clamp_dim(cfg_wdata);
				REG_INNER_DIM: dims_q.inner_dim <= clamp_dim(cfg_wdata);
				REG_B_COLS:    dims_q.b_cols    <= clamp_dim(cfg_wdata);
				default: ;
			endcase
		end
	end

	mm_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.row      (row),
		.col      (col),
		.value    (value),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd_data (push_data)
	);

	mm_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (push_data),
		.pop       (cmd_pop),
		.pop_data  (pop_data),
		.full      (cmd_full),
		.empty     (cmd_empty)
	);

	mm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dims      (dims_q),
		.cmd_empty (cmd_empty),
		.cmd_data  (pop_data),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_row   (out_row),
		.out_col   (out_col),
		.product   (product),
		.saturated (saturated),
		.last      (last)
	);

`ifndef SYNTHESIS
	// The queue is never pushed while full.
	assert property (@(posedge clk) disable iff (!arst_n) cmd_push |-> !cmd_full)
		else $error("command pushed into a full queue");

	// The last result sits at the bottom right corner of the product.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |->
			(DIM_W'(out_row) + DIM_W'(1)) == dims_q.a_rows &&
			(DIM_W'(out_col) + DIM_W'(1)) == dims_q.b_cols)
		else $error("last mark away from the final element");

	// A clipped result holds one of the two range limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			product == {1'b0, {(VAL_W-1){1'b1}}} || product == {1'b1, {(VAL_W-1){1'b0}}})
		else $error("clipped result is not a range limit");
`endif

endmodule

`default_nettype wire
